// ===== sv/rhpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rhpm_pkg
// Shared types, constants and mod-101 helpers of the rolling hash matcher.
// ----------------------------------------------------------------------------
package rhpm_pkg;

	localparam int PATTERN_MAX   = 32;
	localparam int POSITION_BITS = 16;

	localparam int PAT_AW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
	localparam int HASH_W  = 7;
	localparam int DIFF_W  = 14;
	localparam int MODULUS = 101;
	// floor(2^20 / 101); the estimate it gives is never more than one too small.
	localparam int MOD_RECIP = 10381;

	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	localparam logic FUNC_PATTERN = 1'b0;
	localparam logic FUNC_TEXT    = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] byte_value;
		logic       last;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [15:0] match_start;
	} result_t;

	typedef enum logic [1:0] {
		KIND_PAT       = 2'd0,
		KIND_TEXT      = 2'd1,
		KIND_TEXT_LAST = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} qitem_t;

	// x mod 101 by reciprocal multiplication and one corrective subtraction.
	function automatic logic [HASH_W-1:0] mod101(input logic [15:0] x);
		logic [29:0] prod;
		logic [9:0]  q;
		logic [15:0] r;
		prod = 30'(x) * 30'(MOD_RECIP);
		q    = prod[29:20];
		r    = x - (16'(q) * 16'(MODULUS));
		if (r >= 16'(MODULUS)) begin
			r = r - 16'(MODULUS);
		end
		return r[HASH_W-1:0];
	endfunction

	function automatic logic [HASH_W-1:0] byte_mod101(input logic [7:0] b);
		logic [7:0] r;
		if (b >= 8'(2 * MODULUS)) begin
			r = b - 8'(2 * MODULUS);
		end else if (b >= 8'(MODULUS)) begin
			r = b - 8'(MODULUS);
		end else begin
			r = b;
		end
		return r[HASH_W-1:0];
	endfunction

	// Ring slot that lies len entries behind ptr.
	function automatic logic [PAT_AW-1:0] ring_back(input logic [PAT_AW-1:0] ptr,
			input logic [LEN_W-1:0] len);
		logic [LEN_W:0] s;
		s = (LEN_W+1)'(ptr) + (LEN_W+1)'(PATTERN_MAX) - (LEN_W+1)'(len);
		if (s >= (LEN_W+1)'(PATTERN_MAX)) begin
			s = s - (LEN_W+1)'(PATTERN_MAX);
		end
		return s[PAT_AW-1:0];
	endfunction

	function automatic logic [PAT_AW-1:0] ring_inc(input logic [PAT_AW-1:0] a);
		return (a == PAT_AW'(PATTERN_MAX - 1)) ? '0 : a + PAT_AW'(1);
	endfunction

endpackage

// ===== sv/rhpm_ram.sv =====
// ----------------------------------------------------------------------------
// rhpm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rhpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/rhpm_front.sv =====
// ----------------------------------------------------------------------------
// rhpm_front
// Accepts input beats, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module rhpm_front import rhpm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	output logic   item_stall,
	input  item_t  item,
	output logic   q_valid,
	output qitem_t q_item,
	input  logic   q_pop
);

	qitem_t            entry_q [QDEPTH];
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	qitem_t            cls;
	logic              push;
	logic              pop;

	always_comb begin
		cls.data = item.byte_value;
		if (item.func == FUNC_TEXT) begin
			cls.kind = item.last ? KIND_TEXT_LAST : KIND_TEXT;
		end else begin
			cls.kind = KIND_PAT;
		end
	end

	assign item_stall = (count_q == QCNT_W'(QDEPTH));
	assign push       = item_valid && !item_stall;
	assign pop        = q_pop && q_valid;
	assign q_valid    = (count_q != '0);
	assign q_item     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/rhpm_back.sv =====
// ----------------------------------------------------------------------------
// rhpm_back
// Sequencer that updates the hashes, verifies candidate windows and reports.
// ----------------------------------------------------------------------------
module rhpm_back import rhpm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	input  qitem_t  q_item,
	output logic    q_pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_PAT    = 9'b000000010,
		ST_PWR    = 9'b000000100,
		ST_HASH   = 9'b000001000,
		ST_RED1   = 9'b000010000,
		ST_RED2   = 9'b000100000,
		ST_CHECK  = 9'b001000000,
		ST_VERIFY = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [LEN_W-1:0]         len_q, len_d;
	logic [HASH_W-1:0]        ph_q, ph_d;
	logic [HASH_W-1:0]        hp_q, hp_d;
	logic                     pend_q, pend_d;
	logic [HASH_W-1:0]        th_q, th_d;
	logic [POSITION_BITS-1:0] cnt_q, cnt_d;
	logic                     rep_q, rep_d;
	logic [PAT_AW-1:0]        ptr_q, ptr_d;
	logic [LEN_W-1:0]         fill_q, fill_d;
	logic                     result_valid_q, result_valid_d;

	logic [7:0]               b_q, b_d;
	logic                     last_q, last_d;
	logic [DIFF_W-1:0]        diff_q, diff_d;
	logic [HASH_W-1:0]        t_q, t_d;
	logic [LEN_W-1:0]         k_q, k_d;
	logic [PAT_AW-1:0]        vaddr_q, vaddr_d;
	logic                     hit_q, hit_d;
	result_t                  result_q, result_d;

	logic                     pat_we;
	logic [PAT_AW-1:0]        pat_waddr;
	logic [PAT_AW-1:0]        pat_raddr;
	logic [7:0]               pat_rdata;
	logic                     ring_we;
	logic [PAT_AW-1:0]        ring_raddr;
	logic [7:0]               ring_rdata;

	logic [LEN_W-1:0]         eff_len;
	logic [HASH_W-1:0]        eff_ph;
	logic [HASH_W-1:0]        out_mod;
	logic [PAT_AW-1:0]        win_start;
	logic [POSITION_BITS-1:0] start_pos;
	logic                     emit;
	logic                     out_free;

	rhpm_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pattern_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (b_q),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	rhpm_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ptr_q),
		.wdata (b_q),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	assign eff_len   = pend_q ? '0 : len_q;
	assign eff_ph    = pend_q ? '0 : ph_q;
	assign out_mod   = byte_mod101(ring_rdata);
	assign win_start = ring_back(ptr_q, len_q);
	// An empty pattern always reports its match at the start of the text.
	assign start_pos = (len_q == '0) ? '0
		: (cnt_q == POS_MAX) ? POS_MAX
		: cnt_q + POSITION_BITS'(1) - POSITION_BITS'(len_q);
	assign emit      = hit_q || (last_q && !rep_q);
	assign out_free  = !result_valid_q || !result_stall;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		state_d        = state_q;
		len_d          = len_q;
		ph_d           = ph_q;
		hp_d           = hp_q;
		pend_d         = pend_q;
		th_d           = th_q;
		cnt_d          = cnt_q;
		rep_d          = rep_q;
		ptr_d          = ptr_q;
		fill_d         = fill_q;
		result_valid_d = result_valid_q && result_stall;
		b_d            = b_q;
		last_d         = last_q;
		diff_d         = diff_q;
		t_d            = t_q;
		k_d            = k_q;
		vaddr_d        = vaddr_q;
		hit_d          = hit_q;
		result_d       = result_q;
		pat_we         = 1'b0;
		pat_waddr      = eff_len[PAT_AW-1:0];
		pat_raddr      = '0;
		ring_we        = 1'b0;
		ring_raddr     = win_start;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					b_d    = q_item.data;
					last_d = (q_item.kind == KIND_TEXT_LAST);
					unique case (q_item.kind)
						KIND_PAT: state_d = ST_PAT;
						KIND_TEXT, KIND_TEXT_LAST: begin
							if (len_q == '0) begin
								// An empty pattern matches at the very first text byte.
								hit_d   = !rep_q;
								state_d = ST_DONE;
							end else begin
								state_d = ST_HASH;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_PAT: begin
				if (pend_q) begin
					pend_d = 1'b0;
					len_d  = '0;
					ph_d   = '0;
					hp_d   = HASH_W'(1);
					th_d   = '0;
					cnt_d  = '0;
					rep_d  = 1'b0;
					ptr_d  = '0;
					fill_d = '0;
				end
				state_d = ST_IDLE;
				if (eff_len < LEN_W'(PATTERN_MAX)) begin
					pat_we = 1'b1;
					ph_d   = mod101(16'({eff_ph, b_q}));
					len_d  = eff_len + LEN_W'(1);
					if (eff_len != '0) begin
						state_d = ST_PWR;
					end
				end
			end
			ST_PWR: begin
				hp_d    = mod101(16'({hp_q, 8'h00}));
				state_d = ST_IDLE;
			end
			ST_HASH: begin
				ring_we = 1'b1;
				ptr_d   = ring_inc(ptr_q);
				if (fill_q >= len_q) begin
					// Remove the byte that leaves the window before shifting in the new one.
					diff_d  = DIFF_W'(th_q) + DIFF_W'(MODULUS * MODULUS)
						- (DIFF_W'(out_mod) * DIFF_W'(hp_q));
					state_d = ST_RED1;
				end else begin
					th_d    = mod101(16'({th_q, b_q}));
					fill_d  = fill_q + LEN_W'(1);
					state_d = ST_CHECK;
				end
			end
			ST_RED1: begin
				t_d     = mod101(16'(diff_q));
				state_d = ST_RED2;
			end
			ST_RED2: begin
				th_d    = mod101(16'({t_q, b_q}));
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!rep_q && (fill_q == len_q) && (th_q == ph_q)) begin
					ring_raddr = win_start;
					pat_raddr  = '0;
					vaddr_d    = ring_inc(win_start);
					k_d        = LEN_W'(1);
					state_d    = ST_VERIFY;
				end else begin
					hit_d   = 1'b0;
					state_d = ST_DONE;
				end
			end
			ST_VERIFY: begin
				ring_raddr = vaddr_q;
				pat_raddr  = k_q[PAT_AW-1:0];
				if (ring_rdata != pat_rdata) begin
					hit_d   = 1'b0;
					state_d = ST_DONE;
				end else if (k_q == len_q) begin
					hit_d   = 1'b1;
					state_d = ST_DONE;
				end else begin
					vaddr_d = ring_inc(vaddr_q);
					k_d     = k_q + LEN_W'(1);
				end
			end
			ST_DONE: begin
				if (!emit || out_free) begin
					if (emit) begin
						result_valid_d       = 1'b1;
						result_d.found       = hit_q;
						result_d.match_start = hit_q ? 16'(start_pos) : 16'd0;
					end
					if (cnt_q != POS_MAX) begin
						cnt_d = cnt_q + POSITION_BITS'(1);
					end
					rep_d = rep_q || hit_q;
					if (last_q) begin
						th_d   = '0;
						cnt_d  = '0;
						rep_d  = 1'b0;
						ptr_d  = '0;
						fill_d = '0;
						pend_d = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			len_q          <= '0;
			ph_q           <= '0;
			hp_q           <= HASH_W'(1);
			pend_q         <= 1'b1;
			th_q           <= '0;
			cnt_q          <= '0;
			rep_q          <= 1'b0;
			ptr_q          <= '0;
			fill_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			len_q          <= len_d;
			ph_q           <= ph_d;
			hp_q           <= hp_d;
			pend_q         <= pend_d;
			th_q           <= th_d;
			cnt_q          <= cnt_d;
			rep_q          <= rep_d;
			ptr_q          <= ptr_d;
			fill_q         <= fill_d;
			result_valid_q <= result_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		b_q      <= b_d;
		last_q   <= last_d;
		diff_q   <= diff_d;
		t_q      <= t_d;
		k_q      <= k_d;
		vaddr_q  <= vaddr_d;
		hit_q    <= hit_d;
		result_q <= result_d;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== sv/rolling_hash_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher
// Rabin-Karp string search with a radix-256, mod-101 rolling hash.
// ----------------------------------------------------------------------------
// Usage: the item channel carries pattern beats (func = 0) and text beats
// (func = 1, last on the final one). The first pattern beat after reset or
// after a text end starts a new pattern; up to 32 bytes are kept. The result
// channel carries one beat per search: found with the start index of the
// first verified match, or not found once the last text beat passes without
// one. Both channels move a beat when valid is high and stall is low.
// Flow: a two-entry queue takes beats while the sequencer works. A pattern
// beat runs a pattern step and, past its first byte, a power step; a text
// beat the hash update with its chained mod-101 reductions and a check. A
// hash hit adds up to pattern length verify steps, comparing the window and
// pattern stores one byte per read; an empty pattern skips to the final step.
// The result register shows each beat on the cycle after its final step.
// Reset clears the pattern, the hashes and the text position; no clearing
// pass is needed. A stalled result holds, and the sequencer waits in its
// final step until the output register is free, filling the queue behind it.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_matcher import rhpm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic   q_valid;
	qitem_t q_item;
	logic   q_pop;

	rhpm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	rhpm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== sv/rhpm_checker.sv =====
// ----------------------------------------------------------------------------
// rhpm_checker
// Port-level checks on the matcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rhpm_checker import rhpm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A result beat that is held back keeps its contents.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	// An input beat that is held off stays offered with the same contents.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled input beat changed");

	// A not-found report never carries a position.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> result.match_start == 16'd0)
		else $error("not-found result with non-zero position");

	// The queue only fills up on the edge right after it took a beat.
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(item_valid && !item_stall))
		else $error("input stall rose without an accepted beat");

endmodule

bind rolling_hash_pattern_matcher rhpm_checker u_rhpm_checker (.*);

// ===== tb/sv/tb_rolling_hash_pattern_matcher.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rolling_hash_pattern_matcher
// Self-checking bench for the rolling hash pattern matcher. A queue of pattern
// and text beats, directed first and then random, is driven with random gaps.
// A search model predicts every found or not-found beat. The monitor compares
// each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rolling_hash_pattern_matcher;
	import rhpm_pkg::*;

	localparam int RADIX        = 256;
	localparam int POS_LIMIT    = (2 ** POSITION_BITS) - 1;
	localparam int MAX_WAIT     = 6;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_BEATS = 1350;
	localparam int HOLD_AFTER   = 10;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 64;
	localparam longint TIMEOUT_NS = 64'd10_000_000;

	typedef struct {
		item_t beat;
		bit    no_gap;
	} pending_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	rolling_hash_pattern_matcher u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #2 clk = ~clk;

	// Search model state.
	logic [7:0] pat_mem [PATTERN_MAX];
	logic [7:0] win_ring [PATTERN_MAX];
	int pat_len, pat_hash, hi_pow, txt_hash, txt_pos, ring_wr, win_fill;
	bit matched, pat_pending;

	result_t  expected_results [$];
	pending_t pending_beats [$];

	int  error_count  = 0;
	int  results_seen = 0;
	int  beats_taken  = 0;
	int  total_beats  = 0;
	int  random_beats = 0;
	int  cycle_count  = 0;
	bit  item_taken   = 1'b0;
	bit  result_taken = 1'b0;

	// Stimulus generation state.
	logic [7:0] gen_pat [PATTERN_MAX];
	int         gen_len = 0;
	logic [7:0] alphabet [4];
	int         alpha_n;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t ns: %s, got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	task automatic clear_text();
		txt_hash = 0;
		txt_pos  = 0;
		matched  = 1'b0;
		ring_wr  = 0;
		win_fill = 0;
	endtask

	task automatic reset_search_model();
		pat_len     = 0;
		pat_hash    = 0;
		hi_pow      = 1;
		pat_pending = 1'b1;
		clear_text();
	endtask

	task automatic predict_beat(input item_t it);
		int b, pos, outb, t, first, k, start;
		bit hit, same, had;
		result_t r;
		b     = int'(it.byte_value);
		hit   = 1'b0;
		start = 0;
		if (it.func == FUNC_PATTERN) begin
			if (pat_pending) begin
				pat_len     = 0;
				pat_hash    = 0;
				hi_pow      = 1;
				pat_pending = 1'b0;
				clear_text();
			end
			if (pat_len < PATTERN_MAX) begin
				pat_mem[pat_len] = it.byte_value;
				if (pat_len > 0) begin
					hi_pow = (hi_pow * RADIX) % MODULUS;
				end
				pat_hash = (pat_hash * RADIX + b) % MODULUS;
				pat_len++;
			end
			return;
		end
		pos = txt_pos;
		if (pat_len == 0) begin
			hit = !matched;
		end else begin
			if (win_fill >= pat_len) begin
				outb = int'(win_ring[(ring_wr + PATTERN_MAX - pat_len) % PATTERN_MAX]);
				t = (txt_hash + MODULUS * MODULUS - (outb % MODULUS) * hi_pow) % MODULUS;
				txt_hash = (t * RADIX + b) % MODULUS;
			end else begin
				txt_hash = (txt_hash * RADIX + b) % MODULUS;
				win_fill++;
			end
			win_ring[ring_wr] = it.byte_value;
			ring_wr = (ring_wr + 1) % PATTERN_MAX;
			if (!matched && win_fill == pat_len && txt_hash == pat_hash) begin
				// Equal hashes only qualify once the window agrees byte for byte.
				same  = 1'b1;
				first = (ring_wr + PATTERN_MAX - pat_len) % PATTERN_MAX;
				for (k = 0; k < pat_len; k++) begin
					if (win_ring[(first + k) % PATTERN_MAX] != pat_mem[k]) begin
						same = 1'b0;
					end
				end
				if (same) begin
					hit   = 1'b1;
					start = (pos >= POS_LIMIT) ? POS_LIMIT : pos + 1 - pat_len;
				end
			end
		end
		if (txt_pos < POS_LIMIT) begin
			txt_pos++;
		end
		if (hit) begin
			matched       = 1'b1;
			r.found       = 1'b1;
			r.match_start = 16'(start);
			expected_results.insert(expected_results.size(), r);
			if (it.last) begin
				clear_text();
				pat_pending = 1'b1;
			end
		end else if (it.last) begin
			had = matched;
			clear_text();
			pat_pending = 1'b1;
			if (!had) begin
				r.found       = 1'b0;
				r.match_start = '0;
				expected_results.insert(expected_results.size(), r);
			end
		end
	endtask

	function automatic int draw_wait();
		// With the cycle count cut into equal stretches, every fourth stretch runs with no idling at all.
		if (((cycle_count / 400) % 4) == 3) begin
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic logic [7:0] pick_byte();
		if (alpha_n == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return alphabet[$urandom_range(0, alpha_n - 1)];
	endfunction

	task automatic add_beat(input logic f, input logic [7:0] b, input logic l,
			input bit no_gap, input bit counted);
		pending_t p;
		p.beat.func       = f;
		p.beat.byte_value = b;
		p.beat.last       = l;
		p.no_gap          = no_gap;
		pending_beats.insert(pending_beats.size(), p);
		if (counted) begin
			random_beats++;
		end
	endtask

	task automatic build_stimulus();
		int mode, sel, len, tlen, ins, k, n;
		bit drop_last;
		logic [7:0] b;
		logic [7:0] text_q [$];

		// Text against the empty pattern that reset leaves: a match at 0.
		add_beat(FUNC_TEXT, 8'h00, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'hFF, 1'b1, 1'b0, 1'b0);
		// A last flag on a pattern beat has no effect.
		add_beat(FUNC_PATTERN, 8'hFF, 1'b1, 1'b0, 1'b0);
		add_beat(FUNC_PATTERN, 8'h00, 1'b0, 1'b0, 1'b0);
		// The match lands on the final text byte.
		add_beat(FUNC_TEXT, 8'h00, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'hFF, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'h00, 1'b1, 1'b0, 1'b0);
		// The held pattern is searched again: first a miss, then a match whose
		// trailing bytes are absorbed.
		add_beat(FUNC_TEXT, 8'h12, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'h34, 1'b1, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'hFF, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'h00, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'hFF, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'h00, 1'b1, 1'b0, 1'b0);
		add_beat(FUNC_PATTERN, 8'h80, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_PATTERN, 8'h7F, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_PATTERN, 8'h01, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'h7F, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'h80, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'h7F, 1'b0, 1'b0, 1'b0);
		add_beat(FUNC_TEXT, 8'h01, 1'b1, 1'b0, 1'b0);

		while (random_beats < RANDOM_BEATS) begin
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					add_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'b0, 1'b1);
				end
			end else begin
				// A small alphabet makes matches and hash collisions common.
				alpha_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 4);
				for (k = 0; k < 4; k++) begin
					alphabet[k] = 8'($urandom_range(0, 255));
				end
				if (mode != 1) begin
					sel = $urandom_range(0, 19);
					if (sel == 0) begin
						len = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 3);
					end else if (sel < 4) begin
						len = $urandom_range(7, PATTERN_MAX);
					end else begin
						len = $urandom_range(1, 6);
					end
					for (k = 0; k < len; k++) begin
						b = pick_byte();
						if (k < PATTERN_MAX) begin
							gen_pat[k] = b;
						end
						add_beat(FUNC_PATTERN, b, 1'($urandom_range(0, 1)), 1'b0,
							k < PATTERN_MAX);
					end
					gen_len = (len > PATTERN_MAX) ? PATTERN_MAX : len;
				end
				tlen = $urandom_range(1, 40);
				text_q.delete();
				for (k = 0; k < tlen; k++) begin
					text_q.insert(text_q.size(), pick_byte());
				end
				if ($urandom_range(0, 1) == 1) begin
					ins = $urandom_range(0, tlen);
					for (k = 0; k < gen_len; k++) begin
						text_q.insert(ins + k, gen_pat[k]);
					end
				end
				// Now and then the text is left open and runs into the beats that follow.
				drop_last = ($urandom_range(0, 9) == 0);
				for (k = 0; k < text_q.size(); k++) begin
					add_beat(FUNC_TEXT, text_q[k],
						(k == text_q.size() - 1) && !drop_last, 1'b0, 1'b1);
				end
			end
		end

		// A closing text beat ends any search that is still open.
		add_beat(FUNC_TEXT, 8'h5A, 1'b1, 1'b0, 1'b0);
	endtask

	// Driver: a new beat goes out at the falling edge once the last one is taken.
	pending_t next_beat;
	int       tx_gap = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_taken) begin
				if (tx_gap > 0) begin
					tx_gap--;
					item_valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					next_beat = pending_beats.pop_front();
					item       <= next_beat.beat;
					item_valid <= 1'b1;
					tx_gap = next_beat.no_gap ? 0 : draw_wait();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: a random wait after each result beat, and one long hold-off
	// that lets the block back up into its input.
	int rx_wait   = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (result_taken) begin
				rx_wait = draw_wait();
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Monitor: checks result beats first, then predicts from the input beat.
	result_t want;

	always @(posedge clk) begin
		cycle_count++;
		item_taken   = arst_n && item_valid && !item_stall;
		result_taken = arst_n && result_valid && !result_stall;
		if (result_taken) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				flag_mismatch("result beat with nothing expected", 32'(result), 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (result.found !== want.found) begin
					flag_mismatch("found", 32'(result.found), 32'(want.found));
				end
				if (result.match_start !== want.match_start) begin
					flag_mismatch("match_start", 32'(result.match_start),
						32'(want.match_start));
				end
			end
		end
		if (item_taken) begin
			beats_taken++;
			predict_beat(item);
		end
	end

	initial begin
		reset_search_model();
		build_stimulus();
		total_beats = pending_beats.size();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		while (beats_taken < total_beats) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/rhpm_pkg.sv
sv/rhpm_ram.sv
sv/rhpm_front.sv
sv/rhpm_back.sv
sv/rolling_hash_pattern_matcher.sv
sv/rhpm_checker.sv
tb/sv/tb_rolling_hash_pattern_matcher.sv
